FILE: sv/waveform_median_baseline_macros.svh
// Assertion macros for the median baseline block
`ifndef WAVEFORM_MEDIAN_BASELINE_MACROS_SVH
`define WAVEFORM_MEDIAN_BASELINE_MACROS_SVH
// assert that a implies b at every clock edge
`define WMB_ASSERT_IMPL(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
// assert that a implies b in the next cycle
`define WMB_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`endif

FILE: sv/wmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wmb_pkg: shared types for the median baseline block
// Sequencer states, sample width, register index and reset value constants.
// ----------------------------------------------------------------------------
package wmb_pkg;
    typedef enum logic [2:0] {
        ST_IDLE,   // waiting for a sample beat
        ST_SHIFT,  // insertion: read entry below
        ST_MOVE,   // insertion: compare, write entry up or place sample
        ST_MED_A,  // median: read first middle entry
        ST_MED_B,  // median: read second middle entry
        ST_OUT     // result held on the master side
    } wmb_state_t;

    // sample width is fixed by the stream field layout
    localparam int SAMPLE_BITS = 14;

    localparam int unsigned REG_SAT_THRESHOLD = 0;
    localparam logic [13:0] SAT_THRESHOLD_RESET = 14'd1000;
endpackage
`default_nettype wire

FILE: sv/waveform_median_baseline.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_median_baseline: median baseline of one digitizer waveform
// Insertion-sorted sample store in one RAM, walked by a small sequencer.
// ----------------------------------------------------------------------------
// A stored sample holds s_tready low for one ST_SHIFT/ST_MOVE pass per entry moved
// up (0..N-1) plus one to place it; a beat into a full store is taken in ST_IDLE alone.
// A last beat then reads the middle entries in ST_MED_A and ST_MED_B; m_tvalid rises
// in ST_OUT, the state after ST_MED_B, and holds until m_tready.
// Throughput: one beat at a time, bounded by the insertion walk through the sample store.
// Reset (aresetn, sync, active low): count 0, minimum all ones, threshold 1000.
module waveform_median_baseline #(
    parameter int MAX_SAMPLES = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [13:0] sample, rest zero
    input  wire logic        s_tlast,   // last sample of the waveform
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [13:0] baseline, [14] rejected,
                                        // [28:15] minimum, rest zero
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import wmb_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = AW + 1;
    localparam int SB = SAMPLE_BITS;

    // sample store: one write port and one read port, registered read
    logic [SB-1:0] mem [MAX_SAMPLES];
    logic [SB-1:0] rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [SB-1:0] mem_wd;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data <= mem[mem_ra];
    end

    wmb_state_t    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SB-1:0] min_reg, min_next;
    logic [SB-1:0] thr_reg;
    logic [SB-1:0] val_reg, val_next;   // sample being inserted
    logic [AW-1:0] pos_reg, pos_next;   // insertion hole
    logic          last_reg, last_next;
    logic [SB-1:0] mid_reg, mid_next;   // first middle entry
    logic          rej_reg, rej_next;

    logic          cfg_wr;
    logic [CW-1:0] idx_b;               // upper middle index n/2
    logic [CW-1:0] idx_a;               // lower middle index (n-1)/2
    logic [SB:0]   pair_sum;

    assign cfg_wr  = psel && penable && pwrite
                     && (paddr == 2'(REG_SAT_THRESHOLD * 4));
    assign pready  = 1'b1;
    assign prdata  = (paddr == 2'(REG_SAT_THRESHOLD * 4)) ? {18'd0, thr_reg} : 32'd0;
    assign idx_b   = count_reg >> 1;
    assign idx_a   = (count_reg - CW'(1)) >> 1;
    assign pair_sum = {1'b0, mid_reg} + {1'b0, rd_data};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= SAT_THRESHOLD_RESET;
        end else if (cfg_wr) begin
            thr_reg <= pwdata[SB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            min_reg   <= '1;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            min_reg   <= min_next;
            last_reg  <= last_next;
        end
        val_reg  <= val_next;
        pos_reg  <= pos_next;
        mid_reg  <= mid_next;
        rej_reg  <= rej_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (count_reg == CW'(MAX_SAMPLES)) begin
                        state_next = s_tlast ? ST_MED_A : ST_IDLE;
                    end else begin
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: state_next = ST_MOVE;
            ST_MOVE: begin
                if (pos_reg != '0 && rd_data > val_reg) begin
                    state_next = ST_SHIFT;
                end else begin
                    state_next = last_reg ? ST_MED_A : ST_IDLE;
                end
            end
            ST_MED_A: state_next = ST_MED_B;
            ST_MED_B: state_next = ST_OUT;
            ST_OUT:   state_next = m_tready ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        count_next = count_reg;
        min_next   = min_reg;
        val_next   = val_reg;
        pos_next   = pos_reg;
        last_next  = last_reg;
        mid_next   = mid_reg;
        rej_next   = rej_reg;
        mem_we     = 1'b0;
        mem_wa     = pos_reg;
        mem_wd     = val_reg;
        mem_ra     = pos_reg - AW'(1);
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    val_next  = s_tdata[SB-1:0];
                    last_next = s_tlast;
                    pos_next  = count_reg[AW-1:0];
                    if (s_tdata[SB-1:0] < min_reg) begin
                        min_next = s_tdata[SB-1:0];
                    end
                end
            end
            ST_SHIFT: ;  // read of entry pos-1 in flight
            ST_MOVE: begin
                mem_we = 1'b1;
                if (pos_reg != '0 && rd_data > val_reg) begin
                    mem_wd   = rd_data;
                    pos_next = pos_reg - AW'(1);
                end else begin
                    count_next = count_reg + CW'(1);
                end
            end
            ST_MED_A: mem_ra = idx_a[AW-1:0];
            ST_MED_B: begin
                mem_ra   = idx_b[AW-1:0];
                mid_next = rd_data;
            end
            ST_OUT: begin
                // keep the upper middle entry on the read port while the beat waits
                mem_ra   = idx_b[AW-1:0];
                m_tvalid = 1'b1;
                if (m_tready) begin
                    count_next = '0;
                    min_next   = '1;
                    last_next  = 1'b0;
                end
            end
            default: ;
        endcase
        // minimum is final here; reject flag settles while the median is read
        if (state_reg == ST_MED_B) begin
            rej_next = min_reg < thr_reg;
        end
    end

    // median: second middle entry sits in rd_data throughout ST_OUT, so form
    // the value combinationally from held mid and the registered read
    logic [SB-1:0] med_val;
    always_comb begin
        if (count_reg[0]) begin
            med_val = rd_data;
        end else begin
            med_val = pair_sum[SB:1];
        end
    end

    assign m_tdata = {3'd0,
                      min_reg,
                      rej_reg,
                      rej_reg ? {SB{1'b0}} : med_val};
endmodule
`default_nettype wire

FILE: sv/wmb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wmb_checker: port-level checks for the median baseline block
// Watches handshakes and result fields only.
// ----------------------------------------------------------------------------
`include "waveform_median_baseline_macros.svh"
module wmb_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);
    // no beat taken while a result waits
    `WMB_ASSERT_IMPL(a_no_in_while_out, aclk, aresetn, m_tvalid, !s_tready)
    // a rejected result carries zero baseline
    `WMB_ASSERT_IMPL(a_rej_zero, aclk, aresetn, m_tvalid && m_tdata[14], m_tdata[13:0] == 14'd0)
    // after a last sample beat the block goes busy
    `WMB_ASSERT_NEXT(a_busy_after_beat, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready)
    // result holds while stalled
    `WMB_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind waveform_median_baseline wmb_checker u_wmb_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
